// File: sv/stfg_pkg.sv
// Shared constants, types and the sine coefficient table for the sine tone frame generator.
// No dependencies.
package stfg_pkg;

  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned FRAME_W    = 7;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned Q_W        = 31;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned MAX_FRAMES_DEF = 64;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd48695774;
  localparam logic [Q_W-1:0]     Q30_ONE          = 31'h4000_0000;

  // sin(pi/2 t) Taylor coefficients, Q30
  localparam logic [Q_W-1:0] K1  = 31'd1686629713;
  localparam logic [Q_W-1:0] K3  = 31'd693598669;
  localparam logic [Q_W-1:0] K5  = 31'd85569310;
  localparam logic [Q_W-1:0] K7  = 31'd5026996;
  localparam logic [Q_W-1:0] K9  = 31'd172272;
  localparam logic [Q_W-1:0] K11 = 31'd3864;

  localparam logic [2:0] HORNER_LAST = 3'd4;

  typedef struct packed {
    logic [PHASE_W-1:0] a;
    logic [PHASE_W-1:0] b;
  } mul_req_t;

  // Horner step coefficients, highest order first after K11
  function automatic logic [Q_W-1:0] horner_coef(input logic [2:0] idx);
    logic [Q_W-1:0] k;
    case (idx)
      3'd0:    k = K9;
      3'd1:    k = K7;
      3'd2:    k = K5;
      3'd3:    k = K3;
      3'd4:    k = K1;
      default: k = K1;
    endcase
    return k;
  endfunction

endpackage

// File: sv/stfg_mul.sv
// Shared 32x32 unsigned multiplier with registered 64-bit product.
// Depends on stfg_pkg.
module stfg_mul (
  input  logic                        clk,
  input  stfg_pkg::mul_req_t          req,
  output logic [stfg_pkg::PROD_W-1:0] prod
);
  import stfg_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(req.a) * PROD_W'(req.b);
  end

endmodule

// File: sv/stfg_core.sv
// Sequencer: start phase, Horner sine evaluation on the shared multiplier, output register.
// Depends on stfg_pkg; drives stfg_mul.
module stfg_core #(
  parameter int unsigned MAX_FRAMES = stfg_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [stfg_pkg::PHASE_W-1:0]  step,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stfg_pkg::PHASE_W-1:0]  start_time,
  input  logic [stfg_pkg::FRAME_W-1:0]  frame_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stfg_pkg::SAMPLE_W-1:0] sample,
  output logic                          last,
  output stfg_pkg::mul_req_t            mul_req,
  input  logic [stfg_pkg::PROD_W-1:0]   prod
);
  import stfg_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PHASE, S_SQ, S_U, S_HMUL, S_HSUB, S_FIN, S_MAG, S_OUT
  } state_t;

  state_t              state;
  logic [PHASE_W-1:0]  phase;
  logic [CNT_W-1:0]    frames_left;
  logic [Q_W-1:0]      u;
  logic [Q_W-1:0]      p;
  logic [2:0]          k_idx;
  logic [SAMPLE_W-1:0] sample_calc;

  logic [Q_W-1:0]      t;
  logic [CNT_W-1:0]    count_clamped;
  logic [16:0]         mag;
  logic [16:0]         mag_neg;
  logic                out_free;

  assign t = phase[30] ? (Q30_ONE - Q_W'(phase[29:0])) : Q_W'(phase[29:0]);
  assign count_clamped = (frame_count > FRAME_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                               : CNT_W'(frame_count);
  assign mag      = prod[61:45];
  assign mag_neg  = (mag > 17'd32768) ? 17'd32768 : mag;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    mul_req.a = PHASE_W'(t);
    mul_req.b = PHASE_W'(t);
    case (state)
      S_IDLE: begin
        mul_req.a = start_time;
        mul_req.b = step;
      end
      S_HMUL: begin
        mul_req.a = PHASE_W'(u);
        mul_req.b = PHASE_W'(p);
      end
      S_FIN: begin
        mul_req.a = PHASE_W'(t);
        mul_req.b = PHASE_W'(p);
      end
      default: begin
        mul_req.a = PHASE_W'(t);
        mul_req.b = PHASE_W'(t);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      frames_left <= '0;
      k_idx       <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && count_clamped != '0) begin
            frames_left <= count_clamped;
            state       <= S_PHASE;
          end
        end
        S_PHASE: begin
          phase <= prod[PHASE_W-1:0];
          state <= S_SQ;
        end
        S_SQ: begin
          state <= S_U;
        end
        S_U: begin
          u     <= prod[60:30];
          p     <= K11;
          k_idx <= '0;
          state <= S_HMUL;
        end
        S_HMUL: begin
          state <= S_HSUB;
        end
        S_HSUB: begin
          p <= horner_coef(k_idx) - prod[60:30];
          if (k_idx == HORNER_LAST) begin
            state <= S_FIN;
          end else begin
            k_idx <= k_idx + 3'd1;
            state <= S_HMUL;
          end
        end
        S_FIN: begin
          state <= S_MAG;
        end
        S_MAG: begin
          if (phase[31]) begin
            sample_calc <= SAMPLE_W'(17'd0 - mag_neg);
          end else begin
            sample_calc <= (mag > 17'd32767) ? 16'h7FFF : mag[SAMPLE_W-1:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            sample      <= sample_calc;
            last        <= (frames_left == CNT_W'(1));
            phase       <= phase + step;
            frames_left <= frames_left - CNT_W'(1);
            state       <= (frames_left == CNT_W'(1)) ? S_IDLE : S_SQ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/sine_tone_frame_generator.sv
// Sine tone generator: a block request (start sample index, frame count) gives one stereo
// sine beat per frame, the last one marked. The start phase product is formed once the
// request is taken, then each frame is made by the single shared 32x32 multiplier
// that runs the squaring, five Horner steps and the final scaling in turn; a block holds the
// input stalled while its frames are made, including any time a finished frame waits on a
// stalled output register. The next request is taken once the last frame sits in the output
// register. Write phase_step only while idle.
// Depends on stfg_pkg, stfg_mul, stfg_core.
module sine_tone_frame_generator #(
  parameter int unsigned MAX_FRAMES = stfg_pkg::MAX_FRAMES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stfg_pkg::PHASE_W-1:0]         phase_step,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [stfg_pkg::PHASE_W-1:0]         start_time,
  input  logic [stfg_pkg::FRAME_W-1:0]         frame_count,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [stfg_pkg::SAMPLE_W-1:0] sample_left,
  output logic signed [stfg_pkg::SAMPLE_W-1:0] sample_right,
  output logic                                 last_frame
);
  import stfg_pkg::*;

  logic [PHASE_W-1:0]  step;
  logic [SAMPLE_W-1:0] sample;
  mul_req_t            mul_req;
  logic [PROD_W-1:0]   prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= PHASE_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step <= phase_step;
    end
  end

  stfg_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  stfg_core #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .start_time  (start_time),
    .frame_count (frame_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample),
    .last        (last_frame),
    .mul_req     (mul_req),
    .prod        (prod)
  );

  assign sample_left  = sample;
  assign sample_right = sample;

endmodule

// File: sv/stfg_checker.sv
// Port-level checks for the sine tone frame generator, bound to the top level.
// Depends on stfg_pkg.
module stfg_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [stfg_pkg::FRAME_W-1:0]         frame_count,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [stfg_pkg::SAMPLE_W-1:0] sample_left,
  input logic signed [stfg_pkg::SAMPLE_W-1:0] sample_right,
  input logic                                 last_frame
);
  import stfg_pkg::*;

  // held beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_left) && $stable(last_frame))
    else $error("output beat changed while stalled");

  a_stereo: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_left == sample_right)
    else $error("left and right samples differ");

  // a nonempty request keeps the input stalled while frames are made
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && frame_count != '0 |=> in_stall)
    else $error("input taken during a block");

  // when idle, a pending beat can only be the block's last one
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    !in_stall && out_valid |-> last_frame)
    else $error("idle with a non-final beat pending");

endmodule

bind sine_tone_frame_generator stfg_checker u_stfg_checker (.*);
